FILE: src/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg - shared definitions for the DFS topological sort engine
// Opcodes, field widths, default sizes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

  // Fixed field widths of the request and result channels
  localparam int VERT_W = 6;
  localparam int CFG_W  = 7;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;

  // Reset value of the vertex count register
  localparam logic [CFG_W-1:0] NUM_VERTICES_RST = 7'd64;

  // Request opcodes
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_STEP,
    ST_POP,
    ST_EDGE,
    ST_NB,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

FILE: src/dfs_topological_sort_top.sv
// ----------------------------------------------------------------------------
// dfs_topological_sort_top - depth-first topological sort engine
// Add-edge request: passes through ST_LD_RD and ST_LD_WR, then ready again;
//   no result.
// Run request: a depth-first walk with finish/pop, then emit, then a clear sweep
//   over all MAX_VERTICES entries; one result per visited vertex.
// Requests are handled one at a time by the single sequencer that
//   walks the adjacency and stack memories.
// Reset (rst_n low, synchronous): clear sweep over all MAX_VERTICES entries, then ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfs_topological_sort_top #(
  parameter int MAX_VERTICES = dts_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = dts_pkg::MAX_EDGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_wr_en,
  input  wire logic [dts_pkg::CFG_W-1:0] cfg_wr_data,
  // request channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_opcode,
  input  wire logic [dts_pkg::VERT_W-1:0] in_src_vertex,
  input  wire logic [dts_pkg::VERT_W-1:0] in_dst_vertex,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [dts_pkg::VERT_W-1:0]     out_vertex,
  output logic                           out_last
);

  localparam int VERT_W = dts_pkg::VERT_W;
  localparam int CFG_W  = dts_pkg::CFG_W;

  // VW: vertex index, CW: vertex count, EIW: edge index, EW: edge index or null
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EIW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int NW  = (CW > CFG_W) ? CW : CFG_W;  // compare width for vertex ids

  localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);
  localparam logic [CW-1:0] VCOUNT_MAX = CW'(MAX_VERTICES);
  localparam logic [VW-1:0] CLR_LAST  = VW'(MAX_VERTICES - 1);

  // --------------------------------------------------------------------------
  // Storage. Every memory has one write port and one registered read port.
  //   head_mem : newest edge of each vertex (null = MAX_EDGES)
  //   seen_mem : visited marks
  //   tgt_mem / link_mem : edge destination and next-older edge of same source
  //   stk_v_mem / stk_c_mem : DFS stack below the top entry
  //   fo_mem   : vertices in finishing order
  // head_mem and seen_mem are cleared by a sweep after reset and after each run.
  // --------------------------------------------------------------------------
  logic [EW-1:0] head_mem  [MAX_VERTICES];
  logic          seen_mem  [MAX_VERTICES];
  logic [VW-1:0] tgt_mem   [MAX_EDGES];
  logic [EW-1:0] link_mem  [MAX_EDGES];
  logic [VW-1:0] stk_v_mem [MAX_VERTICES];
  logic [EW-1:0] stk_c_mem [MAX_VERTICES];
  logic [VW-1:0] fo_mem    [MAX_VERTICES];

  logic [EW-1:0] head_q;
  logic          seen_q;
  logic [VW-1:0] tgt_q;
  logic [EW-1:0] link_q;
  logic [VW-1:0] stk_v_q;
  logic [EW-1:0] stk_c_q;
  logic [VW-1:0] fo_q;

  // Sequencer and datapath registers
  dts_pkg::state_t   state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_num_vertices_r;
  logic [VERT_W-1:0] src_r, src_nxt;
  logic [VERT_W-1:0] dst_r, dst_nxt;
  logic [EW-1:0]     edge_cnt_r, edge_cnt_nxt;
  logic [NW-1:0]     scan_r, scan_nxt;      // outer loop: next start vertex
  logic [CW-1:0]     depth_r, depth_nxt;    // stack depth, top held in registers
  logic [CW-1:0]     fin_cnt_r, fin_cnt_nxt;
  logic [VW-1:0]     top_v_r, top_v_nxt;
  logic [EW-1:0]     top_c_r, top_c_nxt;
  logic [VW-1:0]     nb_v_r, nb_v_nxt;      // neighbor under test
  logic [VW-1:0]     clr_idx_r, clr_idx_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory port controls
  logic [VW-1:0] rd_v_addr;
  logic          head_we;
  logic [VW-1:0] head_waddr;
  logic [EW-1:0] head_wdata;
  logic          seen_we;
  logic [VW-1:0] seen_waddr;
  logic          seen_wdata;
  logic          edge_we;
  logic          stk_we;
  logic [VW-1:0] stk_waddr;
  logic [VW-1:0] stk_raddr;
  logic          fo_we;
  logic [VW-1:0] fo_waddr;
  logic          fo_re;
  logic [VW-1:0] fo_raddr;

  // Effective vertex count: values above MAX_VERTICES saturate
  logic [NW-1:0] nv;
  logic          add_ok;
  logic          tgt_in_range;

  assign nv = (NW'(cfg_num_vertices_r) > NW'(MAX_VERTICES)) ?
              NW'(MAX_VERTICES) : NW'(cfg_num_vertices_r);

  assign add_ok = (NW'(src_r) < nv) && (NW'(dst_r) < nv) && (edge_cnt_r != EDGE_NULL);
  assign tgt_in_range = NW'(tgt_q) < nv;

  assign stk_raddr = VW'(depth_r - CW'(2));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dts_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == dts_pkg::OP_RUN) ? dts_pkg::ST_SCAN : dts_pkg::ST_LD_RD;
        end
      end
      dts_pkg::ST_LD_RD:    state_nxt = dts_pkg::ST_LD_WR;
      dts_pkg::ST_LD_WR:    state_nxt = dts_pkg::ST_IDLE;
      dts_pkg::ST_SCAN: begin
        state_nxt = (scan_r == nv) ? dts_pkg::ST_EMIT_RD : dts_pkg::ST_SCAN_CHK;
      end
      dts_pkg::ST_SCAN_CHK: begin
        state_nxt = seen_q ? dts_pkg::ST_SCAN : dts_pkg::ST_STEP;
      end
      dts_pkg::ST_STEP: begin
        if (top_c_r != EDGE_NULL) begin
          state_nxt = dts_pkg::ST_EDGE;
        end else if (depth_r == CW'(1)) begin
          state_nxt = dts_pkg::ST_SCAN;
        end else begin
          state_nxt = dts_pkg::ST_POP;
        end
      end
      dts_pkg::ST_POP:      state_nxt = dts_pkg::ST_STEP;
      dts_pkg::ST_EDGE: begin
        state_nxt = tgt_in_range ? dts_pkg::ST_NB : dts_pkg::ST_STEP;
      end
      dts_pkg::ST_NB:       state_nxt = dts_pkg::ST_STEP;
      dts_pkg::ST_EMIT_RD: begin
        state_nxt = (fin_cnt_r == '0) ? dts_pkg::ST_CLEAR : dts_pkg::ST_EMIT_OUT;
      end
      dts_pkg::ST_EMIT_OUT: begin
        if (out_ready) begin
          state_nxt = dts_pkg::ST_EMIT_RD;
        end
      end
      dts_pkg::ST_CLEAR: begin
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = dts_pkg::ST_IDLE;
        end
      end
      default:              state_nxt = dts_pkg::ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control and register next values
  // --------------------------------------------------------------------------
  always_comb begin
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    edge_cnt_nxt = edge_cnt_r;
    scan_nxt     = scan_r;
    depth_nxt    = depth_r;
    fin_cnt_nxt  = fin_cnt_r;
    top_v_nxt    = top_v_r;
    top_c_nxt    = top_c_r;
    nb_v_nxt     = nb_v_r;
    clr_idx_nxt  = clr_idx_r;
    out_last_nxt = out_last_r;

    rd_v_addr  = scan_r[VW-1:0];
    head_we    = 1'b0;
    head_waddr = clr_idx_r;
    head_wdata = EDGE_NULL;
    seen_we    = 1'b0;
    seen_waddr = clr_idx_r;
    seen_wdata = 1'b0;
    edge_we    = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = VW'(depth_r - CW'(1));
    fo_we      = 1'b0;
    fo_waddr   = fin_cnt_r[VW-1:0];
    fo_re      = 1'b0;
    fo_raddr   = VW'(fin_cnt_r - CW'(1));

    case (state_r)
      dts_pkg::ST_IDLE: begin
        if (in_valid) begin
          src_nxt     = in_src_vertex;
          dst_nxt     = in_dst_vertex;
          scan_nxt    = '0;
          fin_cnt_nxt = '0;
        end
      end
      dts_pkg::ST_LD_RD: begin
        rd_v_addr = VW'(src_r);
      end
      dts_pkg::ST_LD_WR: begin
        // new edge goes to the head of the source's list
        if (add_ok) begin
          edge_we      = 1'b1;
          head_we      = 1'b1;
          head_waddr   = VW'(src_r);
          head_wdata   = edge_cnt_r;
          edge_cnt_nxt = edge_cnt_r + EW'(1);
        end
      end
      dts_pkg::ST_SCAN: begin
        rd_v_addr = scan_r[VW-1:0];
      end
      dts_pkg::ST_SCAN_CHK: begin
        if (seen_q) begin
          scan_nxt = scan_r + NW'(1);
        end else begin
          seen_we    = 1'b1;
          seen_waddr = scan_r[VW-1:0];
          seen_wdata = 1'b1;
          top_v_nxt  = scan_r[VW-1:0];
          top_c_nxt  = head_q;
          depth_nxt  = CW'(1);
        end
      end
      dts_pkg::ST_STEP: begin
        if (top_c_r == EDGE_NULL) begin
          // top vertex finished
          if (fin_cnt_r != VCOUNT_MAX) begin
            fo_we       = 1'b1;
            fin_cnt_nxt = fin_cnt_r + CW'(1);
          end
          depth_nxt = depth_r - CW'(1);
          if (depth_r == CW'(1)) begin
            scan_nxt = scan_r + NW'(1);
          end
        end
      end
      dts_pkg::ST_POP: begin
        top_v_nxt = stk_v_q;
        top_c_nxt = stk_c_q;
      end
      dts_pkg::ST_EDGE: begin
        rd_v_addr = tgt_q;
        top_c_nxt = link_q;
        nb_v_nxt  = tgt_q;
      end
      dts_pkg::ST_NB: begin
        if (!seen_q && (depth_r < VCOUNT_MAX)) begin
          seen_we    = 1'b1;
          seen_waddr = nb_v_r;
          seen_wdata = 1'b1;
          stk_we     = 1'b1;
          top_v_nxt  = nb_v_r;
          top_c_nxt  = head_q;
          depth_nxt  = depth_r + CW'(1);
        end
      end
      dts_pkg::ST_EMIT_RD: begin
        if (fin_cnt_r == '0) begin
          clr_idx_nxt = '0;
        end else begin
          fo_re        = 1'b1;
          fin_cnt_nxt  = fin_cnt_r - CW'(1);
          out_last_nxt = (fin_cnt_r == CW'(1));
        end
      end
      dts_pkg::ST_EMIT_OUT: begin
      end
      dts_pkg::ST_CLEAR: begin
        head_we      = 1'b1;
        seen_we      = 1'b1;
        edge_cnt_nxt = '0;
        clr_idx_nxt  = (clr_idx_r == CLR_LAST) ? '0 : clr_idx_r + VW'(1);
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= dts_pkg::ST_CLEAR;
      cfg_num_vertices_r <= dts_pkg::NUM_VERTICES_RST;
      edge_cnt_r         <= '0;
      scan_r             <= '0;
      depth_r            <= '0;
      fin_cnt_r          <= '0;
      clr_idx_r          <= '0;
      out_last_r         <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      scan_r     <= scan_nxt;
      depth_r    <= depth_nxt;
      fin_cnt_r  <= fin_cnt_nxt;
      clr_idx_r  <= clr_idx_nxt;
      out_last_r <= out_last_nxt;
      if (cfg_wr_en) begin
        cfg_num_vertices_r <= cfg_wr_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    top_v_r <= top_v_nxt;
    top_c_r <= top_c_nxt;
    nb_v_r  <= nb_v_nxt;
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[rd_v_addr];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    seen_q <= seen_mem[rd_v_addr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      tgt_mem[edge_cnt_r[EIW-1:0]]  <= VW'(dst_r);
      link_mem[edge_cnt_r[EIW-1:0]] <= head_q;
    end
    tgt_q  <= tgt_mem[top_c_r[EIW-1:0]];
    link_q <= link_mem[top_c_r[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_v_mem[stk_waddr] <= top_v_r;
      stk_c_mem[stk_waddr] <= top_c_r;
    end
    stk_v_q <= stk_v_mem[stk_raddr];
    stk_c_q <= stk_c_mem[stk_raddr];
  end

  // finish record: read is enabled so the result holds while stalled
  always_ff @(posedge clk) begin
    if (fo_we) begin
      fo_mem[fo_waddr] <= top_v_r;
    end
    if (fo_re) begin
      fo_q <= fo_mem[fo_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_ready   = (state_r == dts_pkg::ST_IDLE);
  assign out_valid  = (state_r == dts_pkg::ST_EMIT_OUT);
  assign out_vertex = VERT_W'(fo_q);
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

FILE: src/dts_checker.sv
// ----------------------------------------------------------------------------
// dts_checker - port-level checks for the DFS topological sort engine
// Watches the request and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dts_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_opcode,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [dts_pkg::VERT_W-1:0] out_vertex,
  input wire logic                       out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) && $stable(out_last))
    else $error("result changed while stalled");

  // one request at a time: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  // adding an edge produces no result
  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == dts_pkg::OP_ADD_EDGE) |=> !out_valid)
    else $error("result after add-edge request");

  // final result closes the run
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && !in_ready)
    else $error("activity right after final result");

endmodule

bind dfs_topological_sort_top dts_checker u_dts_checker (.*);

`default_nettype wire
